/* rtl/ccl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types, constants and direction tables for the contour-tracing
// component labeller.
// ----------------------------------------------------------------------------
package ccl_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CRD_W    = 7;   // coordinate with one guard bit, also config width
  localparam int LAB_W    = 11;
  localparam int LWORD_W  = LAB_W + 1;  // label word: mark bit on top

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_LABEL = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] PIX_BG      = 2'd0;
  localparam logic [1:0] PIX_FG      = 2'd1;
  localparam logic [1:0] PIX_MISSING = 2'd2;

  localparam logic [LWORD_W-1:0] LWORD_MARK = {1'b1, {LAB_W{1'b0}}};

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] pixel_row;
    logic [5:0] pixel_col;
    logic [1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [10:0] label;
    logic        is_missing;
    logic [10:0] component_count;
  } out_item_t;

  // Row offset of a trace direction, modulo 2**CRD_W.
  function automatic logic [CRD_W-1:0] step_dy(input logic [2:0] dir);
    logic [CRD_W-1:0] d;
    unique case (dir)
      3'd0, 3'd4: d = '0;
      3'd1, 3'd2, 3'd3: d = CRD_W'(1);
      default: d = '1;
    endcase
    return d;
  endfunction

  // Column offset of a trace direction, modulo 2**CRD_W.
  function automatic logic [CRD_W-1:0] step_dx(input logic [2:0] dir);
    logic [CRD_W-1:0] d;
    unique case (dir)
      3'd2, 3'd6: d = '0;
      3'd0, 3'd1, 3'd7: d = CRD_W'(1);
      default: d = '1;
    endcase
    return d;
  endfunction

endpackage

/* rtl/ccl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ccl_ram #(
  parameter int DW = 8,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/contour_tracing_component_labeller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_tracing_component_labeller
// 8-connected component labelling of a binary image by single-pass contour
// tracing over a pixel memory and a label memory.
//
//   port group | direction | transaction
//   in_        | input     | command item, valid/stall
//   out_       | output    | one result per command, valid/stall
//   APB        | input     | rows_in_use at 0x0, cols_in_use at 0x4
//
// Write and unknown commands answer straight from idle; a read passes through
// a read-wait state. Labelling clears the label memory, then scans each pixel
// through a read and an evaluate state; each traced neighbour probe also takes
// a read and an evaluate state, each contour point a write state, each traced
// contour an end state, the count a done state; both memories are single-port.
// After reset the label memory is cleared; input stalls meanwhile.
// A stalled result holds the output register; input stalls behind it.
// ----------------------------------------------------------------------------
module contour_tracing_component_labeller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ccl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ccl_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ccl_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RDWAIT = 4'd1;
  localparam logic [3:0] ST_CLEAR  = 4'd2;
  localparam logic [3:0] ST_SC_RD  = 4'd3;
  localparam logic [3:0] ST_SC_EV  = 4'd4;
  localparam logic [3:0] ST_TR_RD  = 4'd5;
  localparam logic [3:0] ST_TR_EV  = 4'd6;
  localparam logic [3:0] ST_TR_LP  = 4'd7;
  localparam logic [3:0] ST_TR_END = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic             boot_r, boot_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [LAB_W-1:0] cur_r, cur_nxt;
  logic [LAB_W-1:0] cnt_r, cnt_nxt;
  logic [LAB_W-1:0] count_r, count_nxt;
  logic [ROW_W-1:0] ty_r, ty_nxt, sy_r, sy_nxt, fy_r, fy_nxt, ny_r, ny_nxt;
  logic [COL_W-1:0] tx_r, tx_nxt, sx_r, sx_nxt, fx_r, fx_nxt, nx_r, nx_nxt;
  logic             nin_r, nin_nxt;
  logic [2:0]       dir_r, dir_nxt;
  logic [2:0]       i_r, i_nxt;
  logic             first_r, first_nxt, pass_r, pass_nxt, inner_r, inner_nxt;
  logic [CRD_W-1:0] nr_r, nr_nxt, nc_r, nc_nxt;
  logic [CRD_W-1:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic              pix_we, lab_we;
  logic [ADDR_W-1:0] pix_addr, lab_addr;
  logic [1:0]        pix_wd, pix_q;
  logic [LWORD_W-1:0] lab_wd, lab_q;

  logic             accept, cfg_wr;
  logic [CRD_W-1:0] cfg_val, ny_w, nx_w;
  logic [ROW_W-1:0] py;
  logic [COL_W-1:0] px;
  logic             fg, at_start;

  ccl_ram #(.DW(2), .AW(ADDR_W)) u_pix (
    .clk(clk), .we(pix_we), .addr(pix_addr), .wdata(pix_wd), .rdata(pix_q)
  );
  ccl_ram #(.DW(LWORD_W), .AW(ADDR_W)) u_lab (
    .clk(clk), .we(lab_we), .addr(lab_addr), .wdata(lab_wd), .rdata(lab_q)
  );

  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = !(state_r == ST_IDLE && (!out_valid_r || !out_stall));
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = 32'((paddr[2] == REG_COLS) ? cols_r : rows_r);

  // Clamp a register write to 1..MAX.
  always_comb begin
    cfg_val = pwdata[CRD_W-1:0];
    if (cfg_val == '0) begin
      cfg_val = CRD_W'(1);
    end else if (paddr[2] == REG_ROWS && cfg_val > CRD_W'(MAX_ROWS)) begin
      cfg_val = CRD_W'(MAX_ROWS);
    end else if (paddr[2] == REG_COLS && cfg_val > CRD_W'(MAX_COLS)) begin
      cfg_val = CRD_W'(MAX_COLS);
    end
  end

  assign ny_w = {1'b0, ty_r} + step_dy(dir_r);
  assign nx_w = {1'b0, tx_r} + step_dx(dir_r);
  assign fg   = nin_r && pix_q == PIX_FG;
  assign py   = fg ? ny_r : ty_r;
  assign px   = fg ? nx_r : tx_r;
  assign at_start = py == sy_r && px == sx_r;

  always_comb begin
    state_nxt = state_r;  boot_nxt = boot_r;  clr_nxt = clr_r;
    row_nxt = row_r;  col_nxt = col_r;  cur_nxt = cur_r;  cnt_nxt = cnt_r;
    count_nxt = count_r;
    ty_nxt = ty_r;  tx_nxt = tx_r;  sy_nxt = sy_r;  sx_nxt = sx_r;
    fy_nxt = fy_r;  fx_nxt = fx_r;  ny_nxt = ny_r;  nx_nxt = nx_r;
    nin_nxt = nin_r;  dir_nxt = dir_r;  i_nxt = i_r;
    first_nxt = first_r;  pass_nxt = pass_r;  inner_nxt = inner_r;
    nr_nxt = nr_r;  nc_nxt = nc_r;  rows_nxt = rows_r;  cols_nxt = cols_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    pix_we = 1'b0;  pix_addr = {row_r, col_r};  pix_wd = PIX_BG;
    lab_we = 1'b0;  lab_addr = {row_r, col_r};  lab_wd = '0;

    if (cfg_wr) begin
      if (paddr[2] == REG_COLS) begin
        cols_nxt = cfg_val;
      end else begin
        rows_nxt = cfg_val;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pix_addr = {in_data.pixel_row, in_data.pixel_col};
          lab_addr = {in_data.pixel_row, in_data.pixel_col};
          out_nxt  = '{label: '0, is_missing: 1'b0, component_count: count_r};
          priority case (in_data.command)
            CMD_WRITE: begin
              pix_we = 1'b1;
              pix_wd = (in_data.pixel_value == 2'd3) ? PIX_BG : in_data.pixel_value;
              out_valid_nxt = 1'b1;
            end
            CMD_READ:  state_nxt = ST_RDWAIT;
            CMD_LABEL: begin
              nr_nxt = rows_r;
              nc_nxt = cols_r;
              clr_nxt = '0;
              state_nxt = ST_CLEAR;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_RDWAIT: begin
        out_nxt.is_missing = pix_q == PIX_MISSING;
        out_nxt.label = (pix_q != PIX_MISSING && !lab_q[LAB_W]) ? lab_q[LAB_W-1:0] : '0;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        lab_we = 1'b1;
        lab_addr = clr_r;
        lab_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          boot_nxt = 1'b0;
          row_nxt = '0;
          col_nxt = '0;
          cur_nxt = '0;
          cnt_nxt = '0;
          state_nxt = boot_r ? ST_IDLE : ST_SC_RD;
        end
      end
      ST_SC_RD: state_nxt = ST_SC_EV;
      ST_SC_EV, ST_TR_END: begin
        // default: advance the scan
        state_nxt = ST_SC_RD;
        if (state_r == ST_TR_END) begin
          if (inner_r) begin
            cur_nxt = '0;
          end else begin
            lab_we = 1'b1;
            lab_wd = {1'b0, cur_r};
          end
        end else if (pix_q == PIX_FG) begin
          if (cur_r != '0) begin
            lab_we = 1'b1;
            lab_wd = {1'b0, cur_r};
          end else if (lab_q == '0) begin
            cnt_nxt = cnt_r + 1'b1;
            cur_nxt = cnt_r + 1'b1;
            ty_nxt = row_r;  tx_nxt = col_r;  sy_nxt = row_r;  sx_nxt = col_r;
            dir_nxt = 3'd0;  inner_nxt = 1'b0;
            state_nxt = ST_TR_RD;
          end else begin
            cur_nxt = lab_q[LAB_W-1:0];
          end
        end else if (cur_r != '0) begin
          if (lab_q == '0) begin
            ty_nxt = row_r;  tx_nxt = col_r - 1'b1;
            sy_nxt = row_r;  sx_nxt = col_r - 1'b1;
            dir_nxt = 3'd1;  inner_nxt = 1'b1;
            state_nxt = ST_TR_RD;
          end else begin
            cur_nxt = '0;
          end
        end
        if (state_nxt == ST_TR_RD) begin
          first_nxt = 1'b1;
          pass_nxt = 1'b0;
          i_nxt = '0;
        end else if ({1'b0, col_r} + 1'b1 == nc_r) begin
          col_nxt = '0;
          cur_nxt = '0;
          if ({1'b0, row_r} + 1'b1 == nr_r) begin
            state_nxt = ST_DONE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ST_TR_RD: begin
        ny_nxt = ny_w[ROW_W-1:0];
        nx_nxt = nx_w[COL_W-1:0];
        nin_nxt = ny_w < nr_r && nx_w < nc_r;
        pix_addr = {ny_w[ROW_W-1:0], nx_w[COL_W-1:0]};
        state_nxt = ST_TR_EV;
      end
      ST_TR_EV: begin
        if (!fg) begin
          // mark background probe, turn clockwise
          lab_we = nin_r;
          lab_addr = {ny_r, nx_r};
          lab_wd = LWORD_MARK;
          dir_nxt = dir_r + 1'b1;
          i_nxt = i_r + 1'b1;
          state_nxt = ST_TR_RD;
        end else begin
          ty_nxt = ny_r;
          tx_nxt = nx_r;
        end
        if (fg || i_r == 3'd6) begin
          i_nxt = '0;
          state_nxt = ST_TR_LP;
          if (first_r) begin
            first_nxt = 1'b0;
            fy_nxt = py;
            fx_nxt = px;
            if (at_start) begin
              state_nxt = ST_TR_END;
            end
          end else if (at_start) begin
            pass_nxt = 1'b1;
          end else if (pass_r) begin
            pass_nxt = 1'b0;
            if (py == fy_r && px == fx_r) begin
              state_nxt = ST_TR_END;
            end
          end
        end
      end
      ST_TR_LP: begin
        dir_nxt = dir_r + 3'd6;
        lab_we = 1'b1;
        lab_addr = {ty_r, tx_r};
        lab_wd = {1'b0, cur_r};
        state_nxt = ST_TR_RD;
      end
      ST_DONE: begin
        count_nxt = cnt_r;
        out_nxt = '{label: '0, is_missing: 1'b0, component_count: cnt_r};
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      boot_r <= 1'b1;
      clr_r <= '0;
      count_r <= '0;
      rows_r <= CRD_W'(MAX_ROWS);
      cols_r <= CRD_W'(MAX_COLS);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      boot_r <= boot_nxt;
      clr_r <= clr_nxt;
      count_r <= count_nxt;
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;  col_r <= col_nxt;  cur_r <= cur_nxt;  cnt_r <= cnt_nxt;
    ty_r <= ty_nxt;  tx_r <= tx_nxt;  sy_r <= sy_nxt;  sx_r <= sx_nxt;
    fy_r <= fy_nxt;  fx_r <= fx_nxt;  ny_r <= ny_nxt;  nx_r <= nx_nxt;
    nin_r <= nin_nxt;  dir_r <= dir_nxt;  i_r <= i_nxt;
    first_r <= first_nxt;  pass_r <= pass_nxt;  inner_r <= inner_nxt;
    nr_r <= nr_nxt;  nc_r <= nc_nxt;  out_r <= out_nxt;
  end

endmodule

/* rtl/ccl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_checker
// Port-level checks on the labeller: result holding, input back-pressure,
// idle after reset and pready.
module ccl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ccl_pkg::out_item_t out_data,
  input logic               pready
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("transaction taken while result blocked");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("activity right after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind contour_tracing_component_labeller ccl_checker u_ccl_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
  .pready(pready)
);
